@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/u8u2_pkg.sv @@
`timescale 1ns / 1ps

package u8u2_pkg;

  // One byte of the incoming string.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } byte_req_t;

  // One decoded result.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        decode_error;
    logic        string_done;
  } result_t;

  // Class of a byte as seen by the front end.
  typedef enum logic [2:0] {
    TK_ASCII = 3'd0,
    TK_LEAD2 = 3'd1,
    TK_LEAD3 = 3'd2,
    TK_CONT  = 3'd3,
    TK_BAD   = 3'd4
  } tok_kind_t;

  // Classified byte travelling from the front end to the decoder.
  typedef struct packed {
    tok_kind_t  kind;
    logic [6:0] data;
    logic       last;
  } token_t;

  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

endpackage

@@ design/u8u2_front.sv @@
`timescale 1ns / 1ps

module u8u2_front import u8u2_pkg::*; (
  input  logic      push,
  input  logic      full,
  input  byte_req_t byte_req,
  output logic      wr_en,
  output token_t    tok
);

  logic [7:0] b;

  assign b     = byte_req.byte_in;
  assign wr_en = push && !full;

  // Each byte is sorted into its class and reduced to its payload bits.
  always_comb begin
    tok.last = byte_req.end_of_string;
    tok.data = 7'd0;
    if (b == 8'h00) begin
      tok.kind = TK_BAD;
    end else if (!b[7]) begin
      tok.kind = TK_ASCII;
      tok.data = b[6:0];
    end else if ((b & MASK_CONT) == PAT_CONT) begin
      tok.kind = TK_CONT;
      tok.data = {1'b0, b[5:0]};
    end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      tok.kind = TK_LEAD2;
      tok.data = {2'b00, b[4:0]};
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      tok.kind = TK_LEAD3;
      tok.data = {3'b000, b[3:0]};
    end else begin
      tok.kind = TK_BAD;
    end
  end

endmodule

@@ design/u8u2_queue.sv @@
`timescale 1ns / 1ps

module u8u2_queue import u8u2_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  token_t wr_tok,
  input  logic   rd_en,
  output token_t rd_tok,
  output logic   full,
  output logic   empty
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  token_t             mem [DEPTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/u8u2_back.sv @@
`timescale 1ns / 1ps

module u8u2_back import u8u2_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tok_valid,
  input  token_t  tok,
  output logic    tok_take,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic [1:0]  pending;
  logic [1:0]  pending_next;
  logic [9:0]  partial;
  logic [9:0]  partial_next;
  logic        hold;
  logic        hold_next;
  logic        out_valid;
  result_t     out_data;
  result_t     res;
  logic        res_valid;
  logic        bad;
  logic        have_unit;
  logic [15:0] unit;

  assign empty    = !out_valid;
  assign result   = out_data;
  assign tok_take = tok_valid && (!out_valid || pop);

  always_comb begin
    pending_next = pending;
    partial_next = partial;
    hold_next    = hold;
    res          = '0;
    res_valid    = 1'b0;
    bad          = 1'b0;
    have_unit    = 1'b0;
    unit         = '0;
    if (hold) begin
      // Dropping the rest of a broken string until its final byte.
      if (tok.last) begin
        hold_next       = 1'b0;
        pending_next    = '0;
        partial_next    = '0;
        res.string_done = 1'b1;
        res_valid       = 1'b1;
      end
    end else begin
      if (pending == 2'd0) begin
        unique case (tok.kind)
          TK_ASCII: begin
            unit      = {9'd0, tok.data};
            have_unit = 1'b1;
          end
          TK_LEAD2: begin
            partial_next = {5'd0, tok.data[4:0]};
            pending_next = 2'd1;
          end
          TK_LEAD3: begin
            partial_next = {6'd0, tok.data[3:0]};
            pending_next = 2'd2;
          end
          default: bad = 1'b1;
        endcase
      end else if (tok.kind != TK_CONT) begin
        bad = 1'b1;
      end else if (pending == 2'd2) begin
        partial_next = {partial[3:0], tok.data[5:0]};
        pending_next = 2'd1;
      end else begin
        unit         = {partial, tok.data[5:0]};
        have_unit    = 1'b1;
        partial_next = '0;
        pending_next = '0;
      end

      if (bad) begin
        pending_next     = '0;
        partial_next     = '0;
        hold_next        = !tok.last;
        res.decode_error = 1'b1;
        res.string_done  = tok.last;
        res_valid        = 1'b1;
      end else if (tok.last) begin
        // A final byte that leaves a sequence open is a truncated string.
        res.string_done = 1'b1;
        res_valid       = 1'b1;
        if (pending_next != 2'd0) begin
          res.decode_error = 1'b1;
        end else begin
          res.code_unit  = unit;
          res.unit_valid = have_unit;
        end
        pending_next = '0;
        partial_next = '0;
      end else if (have_unit) begin
        res.code_unit  = unit;
        res.unit_valid = 1'b1;
        res_valid      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      partial   <= '0;
      hold      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (tok_take) begin
        pending <= pending_next;
        partial <= partial_next;
        hold    <= hold_next;
        if (res_valid) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && res_valid) begin
      out_data <= res;
    end
  end

endmodule

@@ design/utf8_to_ucs2_decoder_core.sv @@
`timescale 1ns / 1ps

// UTF-8 to UCS-2 decoder. Bytes of a string are pushed one per request, with
// end_of_string set on the final byte; one-, two- and three-byte sequences
// come out as 16-bit code units, at most one result per byte. A zero byte, a
// stray or wrong continuation byte, a lead byte of four or more bytes, or a
// string that ends inside a sequence gives one result with decode_error set,
// after which the rest of the string is dropped and only its final byte
// answers, with string_done. Overlong forms are passed through unchecked.
// The block takes one byte per cycle while full is low and returns one result
// per cycle while results are popped: the decoder updates its state for each
// byte that it takes, and a pushed byte is registered in the queue and then
// its result in the result register before that result can be popped.
// A queue of DEPTH classified bytes sits between the byte classifier and the
// decoder, so full rises only when the result side has been stalled long
// enough to fill it; the result register is refilled in the cycle it is
// popped. Bytes that complete nothing give no result.

module utf8_to_ucs2_decoder_core import u8u2_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  byte_req_t byte_req,
  output logic      empty,
  input  logic      pop,
  output result_t   result
);

  // Classified request written into the queue.
  token_t wr_tok;
  logic   wr_en;

  // Head of the queue as seen by the decoder.
  token_t rd_tok;
  logic   q_empty;
  logic   rd_take;

  // The front end sorts each byte into its class as it is accepted.
  u8u2_front u_front (
    .push     (push),
    .full     (full),
    .byte_req (byte_req),
    .wr_en    (wr_en),
    .tok      (wr_tok)
  );

  // The queue lets the front keep accepting while results wait to be taken.
  u8u2_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_tok (wr_tok),
    .rd_en  (rd_take),
    .rd_tok (rd_tok),
    .full   (full),
    .empty  (q_empty)
  );

  // The decoder holds the partial code point and the error state, and owns
  // the result register.
  u8u2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!q_empty),
    .tok       (rd_tok),
    .tok_take  (rd_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

@@ design/u8u2_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8u2_checker import u8u2_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // A result that carries no character has a zero code unit.
  `CHK_NOW(a_unit_zero, !empty && !result.unit_valid, result.code_unit == 16'd0, "unit not zero")

  // A completed character and an error never share one result.
  `CHK_NOW(a_unit_or_err, !empty, !(result.unit_valid && result.decode_error), "unit with error")

  // Every result says something.
  `CHK_NOW(a_not_blank, !empty,
           result.unit_valid || result.decode_error || result.string_done, "blank result")

  // A waiting result stays put until it is taken.
  `CHK_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result changed while held")

endmodule

bind utf8_to_ucs2_decoder_core u8u2_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ dv/utf8_to_ucs2_decoder_core_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the UTF-8 to UCS-2 decoder. Strings of bytes are
// pushed through the input queue one request at a time, and the decoded
// results are popped from the result register. Both sides go quiet at random,
// except for one long stretch in the middle of the run where they never do.
module utf8_to_ucs2_decoder_core_tb;
  import u8u2_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int BYTE_TARGET = 1350;
  localparam int REPORT_LIMIT = 10;
  // Results trail their bytes through the internal queue and the result register.
  localparam int SETTLE_CYCLES = 24;

  typedef logic [7:0] byte_q_t[$];

  // Keeps a model of the decoder state and the results that the accepted byte
  // requests should cause, oldest first.
  class ucs2_scoreboard;
    logic [1:0] bytes_left;
    logic [9:0] payload;
    bit         dropping;
    result_t    expected_units[$];
    int         failures;
    int         checked;

    function void restart();
      bytes_left = '0;
      payload    = '0;
      dropping   = 1'b0;
    endfunction

    function void note_byte(byte_req_t req);
      result_t     r;
      bit          bad;
      bit          have_word;
      logic [15:0] word;
      r         = '0;
      bad       = 1'b0;
      have_word = 1'b0;
      word      = '0;

      // While a broken string is being dropped, only its final byte answers.
      if (dropping) begin
        if (req.end_of_string) begin
          restart();
          r.string_done = 1'b1;
          expected_units.push_back(r);
        end
        return;
      end

      if (bytes_left == 2'd0) begin
        if (req.byte_in == 8'h00) begin
          bad = 1'b1;
        end else if (!req.byte_in[7]) begin
          word      = {8'h00, req.byte_in};
          have_word = 1'b1;
        end else if ((req.byte_in & MASK_LEAD2) == PAT_LEAD2) begin
          payload    = {5'b0, req.byte_in[4:0]};
          bytes_left = 2'd1;
        end else if ((req.byte_in & MASK_LEAD3) == PAT_LEAD3) begin
          payload    = {6'b0, req.byte_in[3:0]};
          bytes_left = 2'd2;
        end else begin
          // Stray continuation, or a lead of four bytes or more.
          bad = 1'b1;
        end
      end else if ((req.byte_in & MASK_CONT) != PAT_CONT) begin
        bad = 1'b1;
      end else if (bytes_left == 2'd2) begin
        payload    = {payload[3:0], req.byte_in[5:0]};
        bytes_left = 2'd1;
      end else begin
        word       = {payload, req.byte_in[5:0]};
        have_word  = 1'b1;
        payload    = '0;
        bytes_left = 2'd0;
      end

      if (bad) begin
        r.decode_error = 1'b1;
        if (req.end_of_string) begin
          restart();
          r.string_done = 1'b1;
        end else begin
          bytes_left = '0;
          payload    = '0;
          dropping   = 1'b1;
        end
        expected_units.push_back(r);
      end else if (req.end_of_string) begin
        // A final byte that leaves a sequence open truncates the string.
        if (bytes_left != 2'd0) begin
          r.decode_error = 1'b1;
        end else if (have_word) begin
          r.code_unit  = word;
          r.unit_valid = 1'b1;
        end
        r.string_done = 1'b1;
        restart();
        expected_units.push_back(r);
      end else if (have_word) begin
        r.code_unit  = word;
        r.unit_valid = 1'b1;
        expected_units.push_back(r);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (expected_units.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result %0d arrived with nothing outstanding: unit %h valid %b error %b done %b",
                   checked, got.code_unit, got.unit_valid, got.decode_error,
                   got.string_done);
        end
        return;
      end
      want = expected_units.pop_front();
      if (got.code_unit !== want.code_unit || got.unit_valid !== want.unit_valid ||
          got.decode_error !== want.decode_error || got.string_done !== want.string_done)
      begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result %0d wrong: expected unit %h valid %b error %b done %b, %s",
                   checked, want.code_unit, want.unit_valid, want.decode_error,
                   want.string_done, "see next line");
          $display("  got unit %h valid %b error %b done %b", got.code_unit,
                   got.unit_valid, got.decode_error, got.string_done);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  byte_req_t byte_req;
  logic      empty;
  logic      pop;
  result_t   result;

  ucs2_scoreboard sb;
  int             bytes_sent;
  int             cycle_count;
  // Set for a long stretch of the random part: neither side idles while it holds.
  bit             steady;

  utf8_to_ucs2_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .byte_req (byte_req),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a run that has not finished by now has hung somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one byte request and returns at the edge that accepts it. Inputs
  // change only just after a rising edge, and the handshake is judged on
  // values read right after the edge, before any register has moved.
  task automatic send_byte(input byte_req_t req);
    while (!steady && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    byte_req <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(req);
    bytes_sent++;
  endtask

  // Sends a whole string, with end_of_string on its last byte only.
  task automatic send_string(input byte_q_t text);
    byte_req_t req;
    for (int i = 0; i < text.size(); i++) begin
      req.byte_in       = text[i];
      req.end_of_string = (i == text.size() - 1);
      send_byte(req);
    end
  endtask

  // Holds the input side quiet until every outstanding result has been popped.
  task automatic wait_for_drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_units.size() != 0) @(posedge clk);
  endtask

  // Builds one random string. Most strings are well formed, made of one-,
  // two- and three-byte characters with random payloads (overlong forms
  // included, as the block does not reject them). Some have one byte
  // overwritten with an arbitrary value, some end inside a sequence, and a
  // few are pure noise.
  function automatic byte_q_t compose_string();
    byte_q_t     s;
    int          pick;
    int          nchars;
    int          where;
    logic [15:0] cp;
    pick   = $urandom_range(99);
    nchars = $urandom_range(1, 8);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
      return s;
    end
    repeat (nchars) begin
      cp = 16'($urandom);
      case ($urandom_range(1, 3))
        1: s.push_back(8'($urandom_range(1, 127)));
        2: begin
          s.push_back({3'b110, cp[10:6]});
          s.push_back({2'b10, cp[5:0]});
        end
        default: begin
          s.push_back({4'b1110, cp[15:12]});
          s.push_back({2'b10, cp[11:6]});
          s.push_back({2'b10, cp[5:0]});
        end
      endcase
    end
    cp = 16'($urandom);
    if (pick < 22) begin
      where    = $urandom_range(s.size() - 1);
      s[where] = 8'($urandom_range(255));
    end else if (pick < 30) begin
      // Leave a sequence open at the end of the string.
      if (cp[15]) begin
        s.push_back({4'b1110, cp[3:0]});
        if (cp[14]) s.push_back({2'b10, cp[9:4]});
      end else begin
        s.push_back({3'b110, cp[4:0]});
      end
    end
    return s;
  endfunction

  // Input side: reset, the directed strings, a full drain, then random strings.
  initial begin
    byte_q_t text;
    clk         = 1'b0;
    rst         = 1'b1;
    push        = 1'b0;
    pop         = 1'b0;
    byte_req    = '0;
    cycle_count = 0;
    bytes_sent  = 0;
    steady      = 1'b0;
    sb          = new();
    sb.restart();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ASCII extremes.
    send_string('{8'h01, 8'h7F});
    // Smallest and largest two-byte forms, the smallest being overlong.
    send_string('{8'hC0, 8'h80, 8'hDF, 8'hBF});
    // Smallest and largest three-byte forms; the last one shows that the
    // final continuation keeps only its six payload bits.
    send_string('{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF});
    // A zero byte as a whole string.
    send_string('{8'h00});
    // A zero byte mid-string: the rest is dropped and only the final byte answers.
    send_string('{8'h41, 8'h00, 8'h42, 8'hC3});
    // A stray continuation byte.
    send_string('{8'h80});
    // A lead of four bytes, then a final byte that is dropped but answers with string_done.
    send_string('{8'hF0, 8'h41});
    // The highest lead byte.
    send_string('{8'hFF});
    // A wrong continuation on the final byte; it is not taken as a new character.
    send_string('{8'hC3, 8'h41});
    // A string that ends inside a three-byte sequence.
    send_string('{8'hE2, 8'h82});

    wait_for_drain();

    while (bytes_sent < BYTE_TARGET) begin
      steady = (bytes_sent >= 600 && bytes_sent < 850);
      text   = compose_string();
      send_string(text);
    end
    steady = 1'b0;
    push <= 1'b0;

    while (sb.expected_units.size() != 0) @(posedge clk);
    // Let any result that should not exist show itself.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: pops at random, with the odd long stall so that the
  // internal queue fills and full is seen from the input side.
  initial begin
    bit take;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!steady && $urandom_range(199) == 0) begin
        repeat ($urandom_range(8, 24)) begin
          pop <= 1'b0;
          @(posedge clk);
        end
      end
      take = steady || ($urandom_range(99) >= 29);
      pop <= take;
      @(posedge clk);
      if (take && !empty) sb.check_result(result);
    end
  end

endmodule
